>>> rtl/ztl_pkg.sv
`default_nettype none
package ztl_pkg;

	localparam int LINE_BITS_DEF  = 24;
	localparam int DEPTH_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF = 8;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_ENTRY_END = 2'd2,
		KIND_ERROR     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_PAREN    = 2'd0,
		ERR_QUOTE    = 2'd1,
		ERR_ESCAPE   = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic        was_quoted;
		logic        owner_left_out;
		logic [23:0] line_number;
		logic [7:0]  token_position;
		err_t        error_code;
		logic        last;
	} result_t;

	// results of one input word: count 0..2, then up to two results
	typedef struct packed {
		logic [1:0] num;
		result_t    r1;
		result_t    r0;
	} step_t;

	function automatic result_t mk_result(kind_t kind, logic [7:0] byte_value,
			logic was_quoted, logic owner_left_out, logic [23:0] line_number,
			logic [7:0] token_position, err_t error_code);
		result_t r;
		r.kind           = kind;
		r.byte_value     = byte_value;
		r.was_quoted     = was_quoted;
		r.owner_left_out = owner_left_out;
		r.line_number    = line_number;
		r.token_position = token_position;
		r.error_code     = error_code;
		r.last           = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ztl_in_if.sv
`default_nettype none
interface ztl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_mark;

	modport source (output valid, output char_code, output end_mark, input ready);
	modport sink (input valid, input char_code, input end_mark, output ready);
endinterface
`default_nettype wire

>>> rtl/ztl_out_if.sv
`default_nettype none
interface ztl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic        was_quoted;
	logic        owner_left_out;
	logic [23:0] line_number;
	logic [7:0]  token_position;
	logic [1:0]  error_code;
	logic        last;

	modport source (output valid, output kind, output byte_value, output was_quoted,
		output owner_left_out, output line_number, output token_position,
		output error_code, output last, input ready);
	modport sink (input valid, input kind, input byte_value, input was_quoted,
		input owner_left_out, input line_number, input token_position,
		input error_code, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/zone_text_lexer_unit.sv
// A word is registered in the input stage, then its results are written to the result queue.
// Throughput: one word per cycle while the result queue has room; a word with two
// results is absorbed by the four-entry result queue.
// Reset (arst_n low): lexer state to start of text, line 1; stages and queue empty.
`default_nettype none
module zone_text_lexer_unit #(
	parameter int LINE_BITS  = ztl_pkg::LINE_BITS_DEF,
	parameter int DEPTH_BITS = ztl_pkg::DEPTH_BITS_DEF,
	parameter int COUNT_BITS = ztl_pkg::COUNT_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ztl_in_if.sink     item,
	ztl_out_if.source  result
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	ztl_pkg::result_t fifo_q [4];
	logic [1:0]       wp_q, rp_q;
	logic [2:0]       count_q;

	ztl_pkg::step_t step;
	logic           space_ok, fire, pop;
	logic [1:0]     wr_n;

	assign space_ok   = (count_q <= 3'd2);
	assign fire       = valid_s1 && space_ok;
	assign item.ready = !valid_s1 || space_ok;
	assign pop        = result.valid && result.ready;
	assign wr_n       = fire ? step.num : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.ready)
			valid_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			char_s1 <= item.char_code;
			end_s1  <= item.end_mark;
		end
	end

	ztl_core #(
		.LINE_BITS  (LINE_BITS),
		.DEPTH_BITS (DEPTH_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_s1),
		.end_mark  (end_s1),
		.step      (step)
	);

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0)
			fifo_q[wp_q] <= step.r0;
		if (wr_n == 2'd2)
			fifo_q[wp_q + 2'd1] <= step.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + wr_n;
			rp_q    <= rp_q + 2'(pop);
			count_q <= count_q + 3'(wr_n) - 3'(pop);
		end
	end

	assign result.valid          = (count_q != 3'd0);
	assign result.kind           = fifo_q[rp_q].kind;
	assign result.byte_value     = fifo_q[rp_q].byte_value;
	assign result.was_quoted     = fifo_q[rp_q].was_quoted;
	assign result.owner_left_out = fifo_q[rp_q].owner_left_out;
	assign result.line_number    = fifo_q[rp_q].line_number;
	assign result.token_position = fifo_q[rp_q].token_position;
	assign result.error_code     = fifo_q[rp_q].error_code;
	assign result.last           = fifo_q[rp_q].last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_room_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (count_q + 3'(step.num) <= 3'd4))
		else $error("core wrote past queue space");

	a_stall_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> valid_s1 && count_q > 3'd2)
		else $error("input stalled without a pending word");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step.num == 2'd2 |-> step.r1.last && !step.r0.last)
		else $error("last flag misplaced on two-result word");

endmodule
`default_nettype wire

>>> rtl/ztl_core.sv
`default_nettype none
module ztl_core #(
	parameter int LINE_BITS  = ztl_pkg::LINE_BITS_DEF,
	parameter int DEPTH_BITS = ztl_pkg::DEPTH_BITS_DEF,
	parameter int COUNT_BITS = ztl_pkg::COUNT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_mark,
	output ztl_pkg::step_t     step
);

	logic                  in_comment_q, in_escape_q, in_quote_q, token_open_q;
	logic                  token_quoted_q, entry_begun_q, owner_skipped_q, halted_q;
	logic [DEPTH_BITS-1:0] paren_depth_q;
	logic [LINE_BITS-1:0]  current_line_q, entry_first_line_q;
	logic [COUNT_BITS-1:0] entry_token_count_q;

	logic                  in_comment_d, in_escape_d, in_quote_d, token_open_d;
	logic                  token_quoted_d, entry_begun_d, owner_skipped_d, halted_d;
	logic [DEPTH_BITS-1:0] paren_depth_d;
	logic [LINE_BITS-1:0]  current_line_d, entry_first_line_d;
	logic [COUNT_BITS-1:0] entry_token_count_d;

	ztl_pkg::result_t res [2];
	logic [1:0]       num;

	always_comb begin
		logic             do_ftok, do_fent, do_err, do_nl, emit_esc, emit_chr, is_space;
		ztl_pkg::err_t    err;
		ztl_pkg::result_t r;

		in_comment_d        = in_comment_q;
		in_escape_d         = in_escape_q;
		in_quote_d          = in_quote_q;
		token_open_d        = token_open_q;
		token_quoted_d      = token_quoted_q;
		entry_begun_d       = entry_begun_q;
		owner_skipped_d     = owner_skipped_q;
		halted_d            = halted_q;
		paren_depth_d       = paren_depth_q;
		current_line_d      = current_line_q;
		entry_first_line_d  = entry_first_line_q;
		entry_token_count_d = entry_token_count_q;

		do_ftok  = 1'b0;
		do_fent  = 1'b0;
		do_err   = 1'b0;
		do_nl    = 1'b0;
		emit_esc = 1'b0;
		emit_chr = 1'b0;
		err      = ztl_pkg::ERR_PAREN;
		res[0]   = '0;
		res[1]   = '0;
		num      = 2'd0;
		r        = '0;
		is_space = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0B)
			|| (char_code == 8'h0C) || (char_code == 8'h0D);

		if (end_mark) begin
			if (!halted_q) begin
				if (in_quote_q) begin
					do_err = 1'b1;
					err    = ztl_pkg::ERR_QUOTE;
				end else if (in_escape_q) begin
					do_err = 1'b1;
					err    = ztl_pkg::ERR_ESCAPE;
				end else if (paren_depth_q != '0) begin
					do_err = 1'b1;
					err    = ztl_pkg::ERR_PAREN;
				end else begin
					do_ftok = 1'b1;
					do_fent = 1'b1;
				end
			end
		end else if (!halted_q) begin
			if (in_comment_q) begin
				if (char_code == ztl_pkg::CH_NEWLINE) begin
					in_comment_d = 1'b0;
					do_ftok      = (paren_depth_q == '0);
					do_fent      = (paren_depth_q == '0);
					do_nl        = 1'b1;
				end
			end else if (in_escape_q) begin
				emit_esc     = 1'b1;
				token_open_d = 1'b1;
				in_escape_d  = 1'b0;
			end else if (char_code == ztl_pkg::CH_BACKSLASH) begin
				in_escape_d  = 1'b1;
				token_open_d = 1'b1;
			end else if (in_quote_q) begin
				if (char_code == ztl_pkg::CH_QUOTE) begin
					in_quote_d     = 1'b0;
					token_quoted_d = 1'b1;
				end else begin
					emit_chr = 1'b1;
				end
				token_open_d = 1'b1;
				do_nl        = (char_code == ztl_pkg::CH_NEWLINE);
			end else if (char_code == ztl_pkg::CH_QUOTE) begin
				in_quote_d     = 1'b1;
				token_quoted_d = 1'b1;
				token_open_d   = 1'b1;
				entry_begun_d  = 1'b1;
			end else if (char_code == ztl_pkg::CH_SEMICOLON) begin
				do_ftok      = 1'b1;
				in_comment_d = 1'b1;
			end else if (char_code == ztl_pkg::CH_LPAREN) begin
				do_ftok = 1'b1;
				if (paren_depth_q == '1) begin
					do_err = 1'b1;
					err    = ztl_pkg::ERR_OVERFLOW;
				end else begin
					paren_depth_d = paren_depth_q + 1'b1;
					entry_begun_d = 1'b1;
				end
			end else if (char_code == ztl_pkg::CH_RPAREN) begin
				do_ftok = 1'b1;
				if (paren_depth_q == '0) begin
					do_err = 1'b1;
					err    = ztl_pkg::ERR_PAREN;
				end else begin
					paren_depth_d = paren_depth_q - 1'b1;
				end
			end else if (char_code == ztl_pkg::CH_NEWLINE) begin
				do_ftok = 1'b1;
				do_fent = (paren_depth_q == '0);
				do_nl   = 1'b1;
			end else if (is_space) begin
				if (!entry_begun_q && entry_token_count_q == '0 && !token_open_q)
					owner_skipped_d = 1'b1;
				do_ftok = 1'b1;
			end else begin
				emit_chr      = 1'b1;
				token_open_d  = 1'b1;
				entry_begun_d = 1'b1;
			end
		end

		// close the open token, then the entry, then report an error
		if (do_ftok && token_open_q) begin
			r = ztl_pkg::mk_result(ztl_pkg::KIND_TOKEN_END, 8'd0, token_quoted_q, 1'b0,
				24'd0, 8'd0, ztl_pkg::ERR_PAREN);
			res[num[0]] = r;
			num = num + 2'd1;
			if (entry_token_count_q != '1)
				entry_token_count_d = entry_token_count_q + 1'b1;
			token_open_d   = 1'b0;
			token_quoted_d = 1'b0;
		end
		if (do_fent) begin
			if (entry_token_count_d != '0) begin
				r = ztl_pkg::mk_result(ztl_pkg::KIND_ENTRY_END, 8'd0, 1'b0,
					owner_skipped_q, 24'(entry_first_line_q), 8'd0, ztl_pkg::ERR_PAREN);
				res[num[0]] = r;
				num = num + 2'd1;
			end
			entry_first_line_d  = (current_line_q == '1) ? current_line_q
				: current_line_q + 1'b1;
			entry_token_count_d = '0;
			owner_skipped_d     = 1'b0;
			entry_begun_d       = 1'b0;
		end
		if (do_err) begin
			r = ztl_pkg::mk_result(ztl_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0,
				24'(current_line_q), 8'(entry_token_count_d), err);
			res[num[0]] = r;
			num = num + 2'd1;
			halted_d = 1'b1;
		end
		if (emit_esc) begin
			res[0] = ztl_pkg::mk_result(ztl_pkg::KIND_BYTE, ztl_pkg::CH_BACKSLASH, 1'b0,
				1'b0, 24'd0, 8'd0, ztl_pkg::ERR_PAREN);
			res[1] = ztl_pkg::mk_result(ztl_pkg::KIND_BYTE, char_code, 1'b0, 1'b0,
				24'd0, 8'd0, ztl_pkg::ERR_PAREN);
			num = 2'd2;
		end
		if (emit_chr) begin
			res[0] = ztl_pkg::mk_result(ztl_pkg::KIND_BYTE, char_code, 1'b0, 1'b0,
				24'd0, 8'd0, ztl_pkg::ERR_PAREN);
			num = 2'd1;
		end
		if (do_nl && current_line_q != '1)
			current_line_d = current_line_q + 1'b1;

		if (num == 2'd1)
			res[0].last = 1'b1;
		else if (num == 2'd2)
			res[1].last = 1'b1;

		// end of text leaves everything at its reset value
		if (end_mark) begin
			in_comment_d        = 1'b0;
			in_escape_d         = 1'b0;
			in_quote_d          = 1'b0;
			token_open_d        = 1'b0;
			token_quoted_d      = 1'b0;
			entry_begun_d       = 1'b0;
			owner_skipped_d     = 1'b0;
			halted_d            = 1'b0;
			paren_depth_d       = '0;
			current_line_d      = LINE_BITS'(1);
			entry_first_line_d  = LINE_BITS'(1);
			entry_token_count_d = '0;
		end
	end

	assign step.num = num;
	assign step.r0  = res[0];
	assign step.r1  = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q        <= 1'b0;
			in_escape_q         <= 1'b0;
			in_quote_q          <= 1'b0;
			token_open_q        <= 1'b0;
			token_quoted_q      <= 1'b0;
			entry_begun_q       <= 1'b0;
			owner_skipped_q     <= 1'b0;
			halted_q            <= 1'b0;
			paren_depth_q       <= '0;
			current_line_q      <= LINE_BITS'(1);
			entry_first_line_q  <= LINE_BITS'(1);
			entry_token_count_q <= '0;
		end else if (fire) begin
			in_comment_q        <= in_comment_d;
			in_escape_q         <= in_escape_d;
			in_quote_q          <= in_quote_d;
			token_open_q        <= token_open_d;
			token_quoted_q      <= token_quoted_d;
			entry_begun_q       <= entry_begun_d;
			owner_skipped_q     <= owner_skipped_d;
			halted_q            <= halted_d;
			paren_depth_q       <= paren_depth_d;
			current_line_q      <= current_line_d;
			entry_first_line_q  <= entry_first_line_d;
			entry_token_count_q <= entry_token_count_d;
		end
	end

endmodule
`default_nettype wire
